@@ hdl/hcr_pkg.sv @@
// Shared constants and types for the hit count rank list.
`default_nettype none

package hcr_pkg;

  // Default sizing of the partition chain.
  localparam int MAX_PARTITIONS_DEF = 16;
  localparam int SCORE_BITS_DEF     = 16;

  // Fixed port field widths.
  localparam int TREE_COUNT_W = 5;
  localparam int PART_W       = 4;
  localparam int SLOT_W       = 4;
  localparam int HIT_SCORE_W  = 16;

  // Per-cycle commands broadcast from the sequencer to every cell.
  typedef struct packed {
    logic restart;  // load identity order and clear scores
    logic credit;   // add one hit to the matched partition
    logic sort;     // swap with a neighbor when out of order
    logic rotate;   // shift toward slot 0, the tail takes the head
  } hcr_ctl_t;

endpackage

`default_nettype wire

@@ hdl/hit_count_rank_list.sv @@
// Top level: ranked list of partitions by hit count, built on a chain of slot cells.
// After a start transfer the block loads and credits, then sorts until no pair is out of
// order; results then follow every cycle, slot 0 first, until the last one.
// A new item is taken only when the sequencer is idle, after the last result is issued.
// The chain bubbles the credited partition up one slot a cycle, then rotates the list out.
// Reset (rst_n, synchronous, active low) clears the sequencer and the partition count;
// the first item after reset always restarts the list.
`default_nettype none

module hit_count_rank_list
  import hcr_pkg::*;
#(
  parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF,
  parameter int SCORE_BITS     = SCORE_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    in_new_pair,
  input  wire logic [TREE_COUNT_W-1:0] in_tree_count,
  input  wire logic                    in_match_valid,
  input  wire logic [PART_W-1:0]       in_matched_partition,
  output logic                         out_valid,
  output logic [SLOT_W-1:0]            out_rank_slot,
  output logic [PART_W-1:0]            out_partition_index,
  output logic [HIT_SCORE_W-1:0]       out_hit_score,
  output logic                         out_last
);

  localparam int N    = MAX_PARTITIONS;
  localparam int IW   = $clog2(N);
  localparam int CW   = $clog2(N + 1);
  localparam int CMPW = (CW > TREE_COUNT_W) ? CW : TREE_COUNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SORT = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] active_r, active_nxt;
  logic          init_r, init_nxt;
  logic [IW-1:0] slot_r, slot_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]      out_slot_r;
  logic [PART_W-1:0]      out_part_r;
  logic [HIT_SCORE_W-1:0] out_score_r;
  logic                   out_last_r, out_last_nxt;

  logic          accept;
  logic          restart;
  logic [CMPW-1:0] tc_ext;
  logic [CMPW-1:0] count_clamp;
  logic [CW-1:0] count_eff;
  logic          credit;
  logic [IW-1:0] m_idx;
  logic [IW-1:0] tail_slot;
  logic          any_inv;
  hcr_ctl_t      ctl;

  logic [IW-1:0] cell_idx   [N];
  logic [SCORE_BITS-1:0] cell_score [N];
  logic [N-1:0]  cell_inv;
  logic [N-1:0]  rot_en;
  logic [N-1:0]  is_tail;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Restart decision and partition count clamp for an incoming transfer.
  always_comb begin
    restart = in_new_pair || !init_r;
    tc_ext  = CMPW'(in_tree_count);
    if (tc_ext == '0) begin
      count_clamp = CMPW'(1);
    end else if (tc_ext > CMPW'(N)) begin
      count_clamp = CMPW'(N);
    end else begin
      count_clamp = tc_ext;
    end
    count_eff = restart ? CW'(count_clamp) : active_r;
    credit    = in_match_valid &&
                (CMPW'(in_matched_partition) < CMPW'(count_eff));
    m_idx     = IW'(in_matched_partition);
    tail_slot = IW'(active_r - CW'(1));
    any_inv   = |cell_inv;
  end

  // Sequencer: load and credit on the transfer, bubble, then rotate the list out.
  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    init_nxt      = init_r;
    slot_nxt      = slot_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = 1'b0;
    ctl           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ctl.restart = restart;
          ctl.credit  = credit;
          active_nxt  = count_eff;
          init_nxt    = 1'b1;
          state_nxt   = S_SORT;
        end
      end
      S_SORT: begin
        ctl.sort = 1'b1;
        slot_nxt = '0;
        if (!any_inv) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        ctl.rotate    = 1'b1;
        out_valid_nxt = 1'b1;
        out_last_nxt  = (slot_r == tail_slot);
        slot_nxt      = slot_r + IW'(1);
        if (slot_r == tail_slot) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      init_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register, loaded from the head of the chain.
  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    if (state_r == S_EMIT) begin
      out_slot_r  <= SLOT_W'(slot_r);
      out_part_r  <= PART_W'(cell_idx[0]);
      out_score_r <= HIT_SCORE_W'(cell_score[0]);
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_rank_slot       = out_slot_r;
  assign out_partition_index = out_part_r;
  assign out_hit_score       = out_score_r;
  assign out_last            = out_last_r;

  // Chain of slot cells; slot 0 holds the best partition.
  for (genvar k = 0; k < N; k++) begin : g_cell
    localparam int UP = (k == 0) ? 0 : k - 1;
    localparam int DN = (k == N - 1) ? k : k + 1;

    assign rot_en[k]  = (CW'(k) < active_r);
    assign is_tail[k] = ((CW'(k) + CW'(1)) == active_r);

    hcr_cell #(
      .IW      (IW),
      .SW      (SCORE_BITS),
      .CELL_ID (k)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .m_idx      (m_idx),
      .up_idx     (cell_idx[UP]),
      .up_score   (cell_score[UP]),
      .dn_inv     ((k == N - 1) ? 1'b0 : cell_inv[DN]),
      .dn_idx     (cell_idx[DN]),
      .dn_score   (cell_score[DN]),
      .head_idx   (cell_idx[0]),
      .head_score (cell_score[0]),
      .rot_en     (rot_en[k]),
      .is_tail    (is_tail[k]),
      .idx        (cell_idx[k]),
      .score      (cell_score[k]),
      .inv_up     (cell_inv[k])
    );
  end

endmodule

`default_nettype wire

@@ hdl/hcr_cell.sv @@
// One rank slot of the chain: holds a partition index and its score.
`default_nettype none

module hcr_cell
  import hcr_pkg::*;
#(
  parameter int IW      = 4,
  parameter int SW      = 16,
  parameter int CELL_ID = 0
) (
  input  wire logic          clk,
  input  wire hcr_ctl_t      ctl,
  input  wire logic [IW-1:0] m_idx,
  input  wire logic [IW-1:0] up_idx,
  input  wire logic [SW-1:0] up_score,
  input  wire logic          dn_inv,
  input  wire logic [IW-1:0] dn_idx,
  input  wire logic [SW-1:0] dn_score,
  input  wire logic [IW-1:0] head_idx,
  input  wire logic [SW-1:0] head_score,
  input  wire logic          rot_en,
  input  wire logic          is_tail,
  output logic      [IW-1:0] idx,
  output logic      [SW-1:0] score,
  output logic               inv_up
);

  logic [IW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] score_r, score_nxt;

  assign idx   = idx_r;
  assign score = score_r;

  // This cell ranks before its upper neighbor, so the pair is out of order.
  always_comb begin
    if (CELL_ID == 0) begin
      inv_up = 1'b0;
    end else begin
      inv_up = (score_r > up_score) || ((score_r == up_score) && (idx_r < up_idx));
    end
  end

  // Next contents of the slot.
  always_comb begin
    idx_nxt   = idx_r;
    score_nxt = score_r;
    if (ctl.restart) begin
      idx_nxt   = IW'(CELL_ID);
      score_nxt = (ctl.credit && (m_idx == IW'(CELL_ID))) ? SW'(1) : '0;
    end else if (ctl.credit) begin
      if ((idx_r == m_idx) && (score_r != {SW{1'b1}})) begin
        score_nxt = score_r + SW'(1);
      end
    end else if (ctl.sort) begin
      if (inv_up) begin
        idx_nxt   = up_idx;
        score_nxt = up_score;
      end else if (dn_inv) begin
        idx_nxt   = dn_idx;
        score_nxt = dn_score;
      end
    end else if (ctl.rotate && rot_en) begin
      if (is_tail) begin
        idx_nxt   = head_idx;
        score_nxt = head_score;
      end else begin
        idx_nxt   = dn_idx;
        score_nxt = dn_score;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    score_r <= score_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/hcr_checker.sv @@
// Port-level checker for the hit count rank list, bound to the top level.
`default_nettype none

module hcr_checker
  import hcr_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic                   out_valid,
  input wire logic [SLOT_W-1:0]      out_rank_slot,
  input wire logic [HIT_SCORE_W-1:0] out_hit_score,
  input wire logic                   out_last
);

  // A start transfer always makes the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after a start transfer");

  // Results of one ranking come out back to back until the last one.
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside a ranking burst");

  // While a ranking is still being emitted no new item can be taken.
  a_busy_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("idle in the middle of a ranking burst");

  // Rank slots count up by one within a burst.
  a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rank_slot != '0) |->
      $past(out_valid) && (out_rank_slot == $past(out_rank_slot) + SLOT_W'(1)))
    else $error("rank slot out of sequence");

  // Scores never rise from one rank slot to the next.
  a_score_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rank_slot != '0) |-> out_hit_score <= $past(out_hit_score))
    else $error("ranking not ordered by score");

endmodule

bind hit_count_rank_list hcr_checker u_hcr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_rank_slot (out_rank_slot),
  .out_hit_score (out_hit_score),
  .out_last      (out_last)
);

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking testbench for the hit count rank list: directed and random traffic.
module tb_top;
  import hcr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPART = MAX_PARTITIONS_DEF;
  localparam logic [HIT_SCORE_W-1:0] SCORE_TOP = {HIT_SCORE_W{1'b1}};

  // One pending command with its idle time after the transfer.
  typedef struct {
    logic                    new_pair;
    logic [TREE_COUNT_W-1:0] tree_count;
    logic                    match_valid;
    logic [PART_W-1:0]       partition;
    int unsigned             gap;
    bit                      drain;
  } rank_cmd_t;

  // One predicted rank position.
  typedef struct {
    logic [SLOT_W-1:0]      slot;
    logic [PART_W-1:0]      part;
    logic [HIT_SCORE_W-1:0] score;
    logic                   last;
  } rank_entry_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    in_new_pair = 1'b0;
  logic [TREE_COUNT_W-1:0] in_tree_count = '0;
  logic                    in_match_valid = 1'b0;
  logic [PART_W-1:0]       in_matched_partition = '0;
  logic                    out_valid;
  logic [SLOT_W-1:0]       out_rank_slot;
  logic [PART_W-1:0]       out_partition_index;
  logic [HIT_SCORE_W-1:0]  out_hit_score;
  logic                    out_last;

  rank_cmd_t   cmd_q[$];
  rank_entry_t predicted_rank_q[$];
  int unsigned idle_left = 0;
  int          cmds_taken = 0;
  int          cmds_total = 0;
  int          mismatch_count = 0;

  // Shadow copy of the partition scores and the ranked order.
  logic [HIT_SCORE_W-1:0] part_score[NPART];
  logic [PART_W-1:0]      part_order[NPART];
  int                     ranked_parts;
  bit                     list_live;

  hit_count_rank_list dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_new_pair          (in_new_pair),
    .in_tree_count        (in_tree_count),
    .in_match_valid       (in_match_valid),
    .in_matched_partition (in_matched_partition),
    .out_valid            (out_valid),
    .out_rank_slot        (out_rank_slot),
    .out_partition_index  (out_partition_index),
    .out_hit_score        (out_hit_score),
    .out_last             (out_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Apply one command to the shadow list and queue the ranking it emits.
  task automatic update_ranking(input logic np, input logic [TREE_COUNT_W-1:0] tc,
                                input logic mv, input logic [PART_W-1:0] mp);
    int          i;
    int          j;
    int          cnt;
    logic [PART_W-1:0] v;
    rank_entry_t e;
    if (np || !list_live) begin
      cnt = int'(tc);
      if (cnt < 1) cnt = 1;
      if (cnt > NPART) cnt = NPART;
      ranked_parts = cnt;
      for (i = 0; i < NPART; i++) begin
        part_score[i] = '0;
        part_order[i] = i[PART_W-1:0];
      end
      list_live = 1'b1;
    end
    // A credit outside the ranked range is dropped, but the list is still emitted.
    if (mv && int'(mp) < ranked_parts) begin
      if (part_score[mp] != SCORE_TOP) part_score[mp] = part_score[mp] + 1'b1;
      // Insertion sort: higher score first, lower index wins a tie.
      for (i = 1; i < ranked_parts; i++) begin
        v = part_order[i];
        j = i;
        while (j > 0 && ((part_score[v] > part_score[part_order[j-1]]) ||
                         (part_score[v] == part_score[part_order[j-1]] &&
                          v < part_order[j-1]))) begin
          part_order[j] = part_order[j-1];
          j--;
        end
        part_order[j] = v;
      end
    end
    for (i = 0; i < ranked_parts; i++) begin
      e.slot  = i[SLOT_W-1:0];
      e.part  = part_order[i];
      e.score = part_score[part_order[i]];
      e.last  = (i == ranked_parts - 1);
      predicted_rank_q = {predicted_rank_q, e};
    end
  endtask

  task automatic add_cmd(input logic np, input int tc, input logic mv, input int mp,
                         input int unsigned gap, input bit drain);
    rank_cmd_t c;
    c.new_pair    = np;
    c.tree_count  = tc[TREE_COUNT_W-1:0];
    c.match_valid = mv;
    c.partition   = mp[PART_W-1:0];
    c.gap         = gap;
    c.drain       = drain;
    cmd_q = {cmd_q, c};
  endtask

  // Driver: predict on each transfer, then present the next command after its gap.
  always @(posedge clk) begin : drive_proc
    rank_cmd_t nxt;
    int        i;
    if (!rst_n) begin
      start          <= 1'b0;
      in_new_pair    <= 1'b0;
      in_tree_count  <= '0;
      in_match_valid <= 1'b0;
      in_matched_partition <= '0;
      idle_left      <= 0;
      for (i = 0; i < NPART; i++) begin
        part_score[i] = '0;
        part_order[i] = i[PART_W-1:0];
      end
      ranked_parts = 0;
      list_live    = 1'b0;
    end else begin
      if (start && !busy) begin
        update_ranking(in_new_pair, in_tree_count, in_match_valid, in_matched_partition);
        cmds_taken++;
      end
      if (!start || !busy) begin
        if (idle_left != 0) begin
          start     <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (cmd_q.size() == 0 ||
                     (cmd_q[0].drain && predicted_rank_q.size() != 0)) begin
          start <= 1'b0;
        end else begin
          nxt = cmd_q.pop_front();
          in_new_pair          <= nxt.new_pair;
          in_tree_count        <= nxt.tree_count;
          in_match_valid       <= nxt.match_valid;
          in_matched_partition <= nxt.partition;
          idle_left            <= nxt.gap;
          start                <= 1'b1;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk) begin : check_proc
    rank_entry_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (predicted_rank_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] unexpected result: slot %0d part %0d score %0d last %0b",
                   $realtime, out_rank_slot, out_partition_index, out_hit_score, out_last);
      end else begin
        want = predicted_rank_q.pop_front();
        if (out_rank_slot !== want.slot || out_partition_index !== want.part ||
            out_hit_score !== want.score || out_last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $write("[%0t] mismatch: exp slot %0d part %0d score %0d last %0b, ", $realtime,
                   want.slot, want.part, want.score, want.last);
            $display("got slot %0d part %0d score %0d last %0b",
                     out_rank_slot, out_partition_index, out_hit_score, out_last);
          end
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : main_seq
    int          k;
    int          r;
    int          fill_count;
    int          tc;
    logic        np;
    logic        mv;
    int          mp;
    int unsigned gap;

    // Directed: forced restart on the first command, clamped counts, ignored credits.
    add_cmd(1'b0, 5, 1'b1, 3, 0, 1'b0);
    add_cmd(1'b0, 9, 1'b1, 4, 1, 1'b0);
    add_cmd(1'b0, 5, 1'b1, 7, 0, 1'b0);
    add_cmd(1'b1, 0, 1'b1, 0, 2, 1'b0);
    add_cmd(1'b0, 0, 1'b1, 1, 0, 1'b0);
    add_cmd(1'b0, 0, 1'b0, 0, 5, 1'b0);
    add_cmd(1'b1, 31, 1'b1, 15, 0, 1'b0);
    add_cmd(1'b0, 31, 1'b1, 0, 0, 1'b0);
    add_cmd(1'b0, 31, 1'b1, 15, 3, 1'b0);
    add_cmd(1'b0, 0, 1'b1, 7, 0, 1'b0);
    add_cmd(1'b0, 0, 1'b0, 15, 20, 1'b0);
    add_cmd(1'b1, 16, 1'b1, 15, 0, 1'b0);
    add_cmd(1'b1, 17, 1'b1, 10, 1, 1'b0);
    add_cmd(1'b1, 4, 1'b1, 3, 0, 1'b0);
    add_cmd(1'b0, 4, 1'b1, 2, 0, 1'b0);
    add_cmd(1'b0, 4, 1'b1, 3, 0, 1'b0);
    add_cmd(1'b0, 4, 1'b1, 9, 0, 1'b0);
    add_cmd(1'b0, 4, 1'b1, 4, 2, 1'b0);
    add_cmd(1'b0, 4, 1'b1, 1, 0, 1'b0);
    add_cmd(1'b0, 4, 1'b1, 0, 0, 1'b0);
    add_cmd(1'b0, 4, 1'b1, 2, 0, 1'b0);

    // Random: mostly in-range credits, some restarts, dropped and empty credits.
    fill_count = 4;
    for (k = 0; k < 256; k++) begin
      np = ($urandom_range(0, 9) == 0);
      r  = $urandom_range(0, 99);
      tc = (r < 70) ? $urandom_range(1, 16) : $urandom_range(0, 31);
      if (np) fill_count = (tc < 1) ? 1 : (tc > NPART) ? NPART : tc;
      mv = ($urandom_range(0, 99) < 85);
      mp = ($urandom_range(0, 99) < 80) ? $urandom_range(0, fill_count - 1)
                                         : $urandom_range(0, 15);
      // Alternate stretches of back-to-back traffic with idled ones.
      if ((k / 20) % 2 == 1) begin
        gap = 0;
      end else begin
        r   = $urandom_range(0, 99);
        gap = (r < 55) ? 0 : (r < 88) ? $urandom_range(1, 4) : $urandom_range(10, 48);
      end
      add_cmd(np, tc, mv, mp, gap, (k == 0 || k == 128));
    end
    cmds_total = cmd_q.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (!(cmds_taken == cmds_total && predicted_rank_q.size() == 0));
    repeat (2 * NPART + 8) @(posedge clk);

    if (mismatch_count == 0 && predicted_rank_q.size() == 0) begin
      $display("hit_count_rank_list regression: pass");
    end else begin
      $display("hit_count_rank_list regression: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #30_000_000;
    $display("hit_count_rank_list regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
hdl/hcr_pkg.sv
hdl/hcr_cell.sv
hdl/hit_count_rank_list.sv
hdl/hcr_checker.sv
bench/tb_top.sv
